// ----- rtl/core/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler package
// Shared widths, codes and types used by the front and back of the scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

	// Field widths of the input items and result records.
	localparam int JOB_W   = 4;
	localparam int PRIO_W  = 8;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 32;
	localparam int KIND_W  = 2;

	// Default number of job slots in the ready queue.
	localparam int DEF_QUEUE_DEPTH = 16;

	// Entries in the command queue between the front and the back.
	localparam int CMD_FIFO_DEPTH = 2;

	// Largest time value; time and finish stamps saturate here.
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Record kinds on the result channel.
	localparam logic [KIND_W-1:0] REC_JOB    = 2'd0;
	localparam logic [KIND_W-1:0] REC_IDLE   = 2'd1;
	localparam logic [KIND_W-1:0] REC_REJECT = 2'd2;

	// Operation carried by a command.
	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	// A classified input item as it travels from the front to the back.
	typedef struct packed {
		op_t                op;
		logic [JOB_W-1:0]   job_id;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} cmd_t;

endpackage

// ----- rtl/core/nps_front.sv -----
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts input items, classifies them into arrival or tick commands and
// holds them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module nps_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [nps_pkg::JOB_W-1:0]   job_id,
	input  logic [nps_pkg::PRIO_W-1:0]  job_priority,
	input  logic [nps_pkg::BURST_W-1:0] job_burst,
	output logic                        cmd_valid,
	input  logic                        cmd_pop,
	output nps_pkg::cmd_t               cmd
);
	import nps_pkg::*;

	localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_FIFO_DEPTH - 1);

	cmd_t             fifo_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             in_cmd;
	logic             push;
	logic             pop;

	// Classify the incoming item.
	always_comb begin
		in_cmd.op     = req_type ? OP_TICK : OP_ARRIVE;
		in_cmd.job_id = job_id;
		in_cmd.prio   = job_priority;
		in_cmd.burst  = job_burst;
	end

	// The queue stalls the input only when every entry is taken.
	assign in_stall  = (count_q == CNT_W'(CMD_FIFO_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/nps_back.sv -----
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the job slots, carries out arrivals and ticks one command at a time
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module nps_back #(
	parameter int QUEUE_DEPTH = nps_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_pop,
	input  nps_pkg::cmd_t              cmd,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [nps_pkg::KIND_W-1:0] record_kind,
	output logic [nps_pkg::JOB_W-1:0]  seg_job,
	output logic [nps_pkg::TIME_W-1:0] seg_start,
	output logic [nps_pkg::TIME_W-1:0] seg_finish,
	output logic [nps_pkg::TIME_W-1:0] turnaround,
	output logic [nps_pkg::TIME_W-1:0] waiting,
	output logic                       last_record
);
	import nps_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [JOB_W-1:0]   job_id;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
		logic [TIME_W-1:0]  order;
	} slot_t;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_FREE      = 9'b000000010,
		S_REJECT    = 9'b000000100,
		S_SCAN      = 9'b000001000,
		S_DECIDE    = 9'b000010000,
		S_EMIT_IDLE = 9'b000100000,
		S_FIN1      = 9'b001000000,
		S_FIN2      = 9'b010000000,
		S_EMIT_JOB  = 9'b100000000
	} state_t;

	state_t               state_q;
	slot_t                mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     cnt_idx;
	logic                 scan_done;
	cmd_t                 cmd_q;

	// Scan pipeline: slot data is registered and arrives in the cycle after its address.
	slot_t                rd_data_s1;
	logic                 cmp_en_s1;
	logic                 slot_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	slot_t                best_q;
	logic                 better;

	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    busy_q;
	logic                 idle_active_q;
	logic [TIME_W-1:0]    idle_begin_q;
	logic [TIME_W-1:0]    enq_cnt_q;
	logic [TIME_W-1:0]    fin_q;
	logic [TIME_W-1:0]    tat_q;

	logic                 now_ge_busy;
	logic [TIME_W-1:0]    now_inc;
	logic [TIME_W:0]      fin_sum;
	logic [TIME_W-1:0]    fin_sat;
	logic [TIME_W-1:0]    burst_ext;
	logic [TIME_W-1:0]    wait_val;
	logic                 mem_we;
	slot_t                wr_slot;

	logic                 out_valid_q;
	logic                 out_free;
	logic [KIND_W-1:0]    out_kind_q;
	logic [JOB_W-1:0]     out_job_q;
	logic [TIME_W-1:0]    out_start_q;
	logic [TIME_W-1:0]    out_finish_q;
	logic [TIME_W-1:0]    out_tat_q;
	logic [TIME_W-1:0]    out_wait_q;
	logic                 out_last_q;

	// Slot counter and its index form.
	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign scan_done = (cnt_q == CNT_W'(QUEUE_DEPTH));

	// A command is taken from the queue as soon as the sequencer is free.
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	// The result register can be loaded when empty or when it drains now.
	assign out_free = !out_valid_q || !out_stall;

	// Candidate comparison: lower priority value wins, then the older job.
	assign better = slot_vld_s1 &&
		(!best_found_q ||
		 (rd_data_s1.prio < best_q.prio) ||
		 ((rd_data_s1.prio == best_q.prio) && (rd_data_s1.order < best_q.order)));

	// Time arithmetic with saturation.
	assign now_ge_busy = (now_q >= busy_q);
	assign now_inc     = (now_q == TIME_MAX) ? TIME_MAX : now_q + 1'b1;
	assign burst_ext   = {{(TIME_W-BURST_W){1'b0}}, best_q.burst};
	assign fin_sum     = {1'b0, busy_q} + {1'b0, burst_ext};
	assign fin_sat     = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
	assign wait_val    = (tat_q >= burst_ext) ? tat_q - burst_ext : '0;

	// An arrival is written into the first free slot found by the search.
	assign mem_we = (state_q == S_FREE) && !scan_done && !valid_q[cnt_idx];

	always_comb begin
		wr_slot.job_id  = cmd_q.job_id;
		wr_slot.prio    = cmd_q.prio;
		wr_slot.burst   = cmd_q.burst;
		wr_slot.arrival = now_q;
		wr_slot.order   = enq_cnt_q;
	end

	// Slot memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_idx] <= wr_slot;
		end
		rd_data_s1 <= mem[cnt_idx];
	end

	// Sequencer, slot valid bits, time keeping and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			cnt_q         <= '0;
			cmp_en_s1     <= 1'b0;
			slot_vld_s1   <= 1'b0;
			rd_idx_s1     <= '0;
			best_found_q  <= 1'b0;
			best_idx_q    <= '0;
			now_q         <= '0;
			busy_q        <= '0;
			idle_active_q <= 1'b0;
			idle_begin_q  <= '0;
			enq_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cnt_q        <= '0;
						cmp_en_s1    <= 1'b0;
						best_found_q <= 1'b0;
						state_q      <= (cmd.op == OP_ARRIVE) ? S_FREE : S_SCAN;
					end
				end
				S_FREE: begin
					if (scan_done) begin
						state_q <= S_REJECT;
					end else if (!valid_q[cnt_idx]) begin
						valid_q[cnt_idx] <= 1'b1;
						enq_cnt_q        <= enq_cnt_q + 1'b1;
						state_q          <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_REJECT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					cmp_en_s1   <= !scan_done;
					slot_vld_s1 <= !scan_done && valid_q[cnt_idx];
					rd_idx_s1   <= cnt_idx;
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cmp_en_s1 && better) begin
						best_found_q <= 1'b1;
						best_idx_q   <= rd_idx_s1;
					end
					if (scan_done && !cmp_en_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!best_found_q) begin
						// Nothing waits: the core idles once its job is done.
						if (now_ge_busy) begin
							if (!idle_active_q) begin
								idle_begin_q  <= busy_q;
								idle_active_q <= 1'b1;
							end
							busy_q <= now_inc;
						end
						now_q   <= now_inc;
						state_q <= S_IDLE;
					end else if (idle_active_q) begin
						state_q <= S_EMIT_IDLE;
					end else if (now_ge_busy) begin
						state_q <= S_FIN1;
					end else begin
						now_q   <= now_inc;
						state_q <= S_IDLE;
					end
				end
				S_EMIT_IDLE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						idle_active_q <= 1'b0;
						if (now_ge_busy) begin
							state_q <= S_FIN1;
						end else begin
							now_q   <= now_inc;
							state_q <= S_IDLE;
						end
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					state_q <= S_EMIT_JOB;
				end
				S_EMIT_JOB: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						busy_q              <= fin_q;
						valid_q[best_idx_q] <= 1'b0;
						now_q               <= now_inc;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture, best candidate, dispatch arithmetic and result payload.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if ((state_q == S_SCAN) && cmp_en_s1 && better) begin
			best_q <= rd_data_s1;
		end
		if (state_q == S_FIN1) begin
			fin_q <= fin_sat;
		end
		if (state_q == S_FIN2) begin
			tat_q <= (fin_q >= best_q.arrival) ? fin_q - best_q.arrival : '0;
		end
		if (out_free) begin
			case (state_q)
				S_REJECT: begin
					out_kind_q   <= REC_REJECT;
					out_job_q    <= cmd_q.job_id;
					out_start_q  <= '0;
					out_finish_q <= '0;
					out_tat_q    <= '0;
					out_wait_q   <= '0;
					out_last_q   <= 1'b1;
				end
				S_EMIT_IDLE: begin
					out_kind_q   <= REC_IDLE;
					out_job_q    <= '0;
					out_start_q  <= idle_begin_q;
					out_finish_q <= busy_q;
					out_tat_q    <= '0;
					out_wait_q   <= '0;
					out_last_q   <= !now_ge_busy;
				end
				S_EMIT_JOB: begin
					out_kind_q   <= REC_JOB;
					out_job_q    <= best_q.job_id;
					out_start_q  <= busy_q;
					out_finish_q <= fin_q;
					out_tat_q    <= tat_q;
					out_wait_q   <= wait_val;
					out_last_q   <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign record_kind = out_kind_q;
	assign seg_job     = out_job_q;
	assign seg_start   = out_start_q;
	assign seg_finish  = out_finish_q;
	assign turnaround  = out_tat_q;
	assign waiting     = out_wait_q;
	assign last_record = out_last_q;

endmodule

// ----- rtl/core/nonpreemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Front end with a command queue feeding a sequencer that owns the job slots.
// ----------------------------------------------------------------------------
// Arrivals enqueue a job into the lowest free slot, stamped with the current
// time; a full queue gives a rejection record. A tick makes the scheduling
// decision for the current time and then advances time by one: when the core
// is free the waiting job with the smallest priority value (oldest first on
// a tie) is dispatched, preceded by any pending idle segment. Items are
// worked one at a time by the back end, while the front end keeps taking up
// to two more. An arrival searches the slots from the lowest for a free one,
// and a tick scans every slot before its decision; a stalled result holds
// the back end until the record can be loaded. The priority search reads the
// slot memory one slot per cycle through its single read port.
module nonpreemptive_priority_scheduler #(
	parameter int QUEUE_DEPTH = nps_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [nps_pkg::JOB_W-1:0]   job_id,
	input  logic [nps_pkg::PRIO_W-1:0]  job_priority,
	input  logic [nps_pkg::BURST_W-1:0] job_burst,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [nps_pkg::KIND_W-1:0]  record_kind,
	output logic [nps_pkg::JOB_W-1:0]   seg_job,
	output logic [nps_pkg::TIME_W-1:0]  seg_start,
	output logic [nps_pkg::TIME_W-1:0]  seg_finish,
	output logic [nps_pkg::TIME_W-1:0]  turnaround,
	output logic [nps_pkg::TIME_W-1:0]  waiting,
	output logic                        last_record
);
	import nps_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// Input side: classification and command queue.
	nps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.job_id       (job_id),
		.job_priority (job_priority),
		.job_burst    (job_burst),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd)
	);

	// Execution side: job slots, scheduling decision and result register.
	nps_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.record_kind (record_kind),
		.seg_job     (seg_job),
		.seg_start   (seg_start),
		.seg_finish  (seg_finish),
		.turnaround  (turnaround),
		.waiting     (waiting),
		.last_record (last_record)
	);

endmodule

// ----- bench/nps_schedule_monitor.sv -----
// ----------------------------------------------------------------------------
// Scheduler schedule monitor
// Watches both channels of the scheduler. Every accepted item updates a
// predicted ready queue and timeline, which gives the segment records that
// are owed. Every result transfer is compared, field by field, with the
// oldest owed record.
// ----------------------------------------------------------------------------
module nps_schedule_monitor #(
	parameter int QUEUE_DEPTH = nps_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        req_type,
	input  logic [nps_pkg::JOB_W-1:0]   job_id,
	input  logic [nps_pkg::PRIO_W-1:0]  job_priority,
	input  logic [nps_pkg::BURST_W-1:0] job_burst,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [nps_pkg::KIND_W-1:0]  record_kind,
	input  logic [nps_pkg::JOB_W-1:0]   seg_job,
	input  logic [nps_pkg::TIME_W-1:0]  seg_start,
	input  logic [nps_pkg::TIME_W-1:0]  seg_finish,
	input  logic [nps_pkg::TIME_W-1:0]  turnaround,
	input  logic [nps_pkg::TIME_W-1:0]  waiting,
	input  logic                        last_record,
	output int                          mismatch_count,
	output int                          records_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import nps_pkg::*;

	// One segment record as the scheduler should emit it.
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [JOB_W-1:0]  job;
		logic [TIME_W-1:0] seg_begin;
		logic [TIME_W-1:0] seg_end;
		logic [TIME_W-1:0] tat;
		logic [TIME_W-1:0] lag;
		logic              last;
	} segment_t;

	// Predicted ready queue.
	logic               slot_used    [QUEUE_DEPTH];
	logic [JOB_W-1:0]   slot_job     [QUEUE_DEPTH];
	logic [PRIO_W-1:0]  slot_prio    [QUEUE_DEPTH];
	logic [BURST_W-1:0] slot_burst   [QUEUE_DEPTH];
	logic [TIME_W-1:0]  slot_arrival [QUEUE_DEPTH];
	logic [TIME_W-1:0]  slot_seq     [QUEUE_DEPTH];

	// Predicted timeline.
	logic [TIME_W-1:0] seq_count;
	logic [TIME_W-1:0] clock_now;
	logic [TIME_W-1:0] core_free_at;
	logic              idle_open;
	logic [TIME_W-1:0] idle_from;

	segment_t expected_segments[$];

	// Time stamps stick at their largest value rather than wrap.
	function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	function automatic segment_t make_seg(input logic [KIND_W-1:0] kind,
			input logic [JOB_W-1:0] job, input logic [TIME_W-1:0] seg_begin,
			input logic [TIME_W-1:0] seg_end, input logic [TIME_W-1:0] tat,
			input logic [TIME_W-1:0] lag);
		segment_t seg;
		seg.kind      = kind;
		seg.job       = job;
		seg.seg_begin = seg_begin;
		seg.seg_end   = seg_end;
		seg.tat       = tat;
		seg.lag       = lag;
		seg.last      = 1'b0;
		return seg;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] record mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		int free_slot;
		int best;
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] tat;
		segment_t batch[$];
		segment_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_used[i] = 1'b0;
			seq_count    = '0;
			clock_now    = '0;
			core_free_at = '0;
			idle_open    = 1'b0;
			idle_from    = '0;
			expected_segments.delete();
		end else begin
			// An accepted input transfer moves the predicted schedule on.
			if (in_valid && !in_stall) begin
				batch.delete();
				if (op_t'(req_type) == OP_ARRIVE) begin
					// Arrivals take the lowest free slot, or are turned away.
					free_slot = -1;
					for (int i = 0; i < QUEUE_DEPTH; i++)
						if (!slot_used[i] && free_slot < 0)
							free_slot = i;
					if (free_slot < 0) begin
						batch.push_back(make_seg(REC_REJECT, job_id, '0, '0, '0, '0));
					end else begin
						slot_used[free_slot]    = 1'b1;
						slot_job[free_slot]     = job_id;
						slot_prio[free_slot]    = job_priority;
						slot_burst[free_slot]   = job_burst;
						slot_arrival[free_slot] = clock_now;
						slot_seq[free_slot]     = seq_count;
						seq_count               = seq_count + 1'b1;
					end
				end else begin
					// Lowest priority value wins; the older job wins a tie.
					best = -1;
					for (int i = 0; i < QUEUE_DEPTH; i++)
						if (slot_used[i] && (best < 0 || slot_prio[i] < slot_prio[best] ||
								(slot_prio[i] == slot_prio[best] &&
								slot_seq[i] < slot_seq[best])))
							best = i;
					if (best < 0) begin
						// Nothing waits: once the core is free the idle stretch grows.
						if (clock_now >= core_free_at) begin
							if (!idle_open) begin
								idle_from = core_free_at;
								idle_open = 1'b1;
							end
							core_free_at = time_plus(clock_now, 1);
						end
					end else begin
						if (idle_open) begin
							batch.push_back(make_seg(REC_IDLE, '0, idle_from, core_free_at,
								'0, '0));
							idle_open = 1'b0;
						end
						if (clock_now >= core_free_at) begin
							fin = time_plus(core_free_at, TIME_W'(slot_burst[best]));
							tat = (fin >= slot_arrival[best]) ? fin - slot_arrival[best] : '0;
							batch.push_back(make_seg(REC_JOB, slot_job[best], core_free_at, fin,
								tat, (tat >= slot_burst[best]) ? tat - slot_burst[best] : '0));
							core_free_at    = fin;
							slot_used[best] = 1'b0;
						end
					end
					clock_now = time_plus(clock_now, 1);
				end
				if (batch.size() > 0)
					batch[batch.size() - 1].last = 1'b1;
				foreach (batch[k])
					expected_segments.push_back(batch[k]);
			end

			// A result transfer must match the oldest owed record.
			if (out_valid && !out_stall) begin
				if (expected_segments.size() == 0) begin
					note_mismatch($sformatf("unexpected record of kind %0d for job %0d",
						record_kind, seg_job));
				end else begin
					oldest = expected_segments.pop_front();
					check_field("record_kind", TIME_W'(record_kind), TIME_W'(oldest.kind));
					check_field("seg_job", TIME_W'(seg_job), TIME_W'(oldest.job));
					check_field("seg_start", seg_start, oldest.seg_begin);
					check_field("seg_finish", seg_finish, oldest.seg_end);
					check_field("turnaround", turnaround, oldest.tat);
					check_field("waiting", waiting, oldest.lag);
					check_field("last_record", TIME_W'(last_record), TIME_W'(oldest.last));
				end
			end
		end
		records_owed <= expected_segments.size();
	end

endmodule

// ----- bench/tb_nonpreemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler testbench
// Drives directed and random arrivals and ticks into the scheduler with
// random gaps and result stalls, including one long result hold-off, and
// gives the verdict from the monitor's mismatch count.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import nps_pkg::*;

	localparam int QUEUE_DEPTH    = DEF_QUEUE_DEPTH;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1070;
	localparam int DRAIN_TICKS    = 200;
	localparam int SQUEEZE_AT     = 400;
	localparam int SQUEEZE_CYCLES = 500;
	localparam int SETTLE_CYCLES  = 4 * (QUEUE_DEPTH + 8);
	localparam int CYCLE_LIMIT    = 800000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic [JOB_W-1:0]   job_id;
	logic [PRIO_W-1:0]  job_priority;
	logic [BURST_W-1:0] job_burst;
	logic               out_valid;
	logic               out_stall;
	logic [KIND_W-1:0]  record_kind;
	logic [JOB_W-1:0]   seg_job;
	logic [TIME_W-1:0]  seg_start;
	logic [TIME_W-1:0]  seg_finish;
	logic [TIME_W-1:0]  turnaround;
	logic [TIME_W-1:0]  waiting;
	logic               last_record;
	int                 mismatch_count;
	int                 records_owed;

	// Stimulus state shared with the result side.
	int items_taken = 0;
	bit calm        = 1'b0;
	bit winding_down = 1'b0;

	nonpreemptive_priority_scheduler #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .job_id(job_id),
		.job_priority(job_priority), .job_burst(job_burst),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .seg_job(seg_job),
		.seg_start(seg_start), .seg_finish(seg_finish),
		.turnaround(turnaround), .waiting(waiting),
		.last_record(last_record)
	);

	nps_schedule_monitor #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_monitor (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .job_id(job_id),
		.job_priority(job_priority), .job_burst(job_burst),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .seg_job(seg_job),
		.seg_start(seg_start), .seg_finish(seg_finish),
		.turnaround(turnaround), .waiting(waiting),
		.last_record(last_record),
		.mismatch_count(mismatch_count), .records_owed(records_owed)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Pause length for either side: mostly none or short, now and then long.
	function automatic int pick_pause();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one item after an optional gap and wait for its transfer.
	task automatic offer(input op_t op, input logic [JOB_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input logic [BURST_W-1:0] burst);
		int gap;
		gap = pick_pause();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		req_type     <= op;
		job_id       <= id;
		job_priority <= prio;
		job_burst    <= burst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_taken++;
	endtask

	// Result side: random stalls, and once a long hold-off to back the block up.
	initial begin
		int hold;
		int squeeze;
		bit squeezed;
		out_stall = 1'b0;
		hold      = 0;
		squeeze   = 0;
		squeezed  = 1'b0;
		forever begin
			@(negedge clk);
			if (!squeezed && items_taken >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				squeeze  = SQUEEZE_CYCLES;
			end
			if (squeeze > 0) begin
				squeeze--;
				out_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (winding_down) begin
				out_stall <= 1'b0;
			end else begin
				hold = pick_pause();
				out_stall <= (hold > 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int sent;
		int phase_len;
		int arrive_pct;
		int r;
		logic [PRIO_W-1:0] prio;
		logic [BURST_W-1:0] burst;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = OP_ARRIVE;
		job_id       = '0;
		job_priority = '0;
		job_burst    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle start, a tie on zero priority with a zero burst, then an idle
		// segment ahead of the first job segment and a job held off while busy.
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		offer(OP_TICK, 4'hF, 8'hFF, 16'hFFFF);
		offer(OP_ARRIVE, 4'h0, 8'hFF, 16'h0001);
		offer(OP_ARRIVE, 4'hF, 8'h00, 16'h0000);
		offer(OP_ARRIVE, 4'h5, 8'h00, 16'h0003);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);

		// Fill the queue with tied and extreme priorities, then one is turned away.
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			offer(OP_ARRIVE, JOB_W'(i), (i % 3 == 0) ? 8'd1 : ((i % 3 == 1) ? 8'd254 : 8'd7),
				BURST_W'(i % 4));
		offer(OP_ARRIVE, 4'hF, 8'hFF, 16'hFFFF);

		// Random phases, each with its own share of arrivals and its own pacing.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(30, 120);
			case ($urandom_range(0, 3))
				0: arrive_pct = 10;
				1: arrive_pct = 30;
				2: arrive_pct = 50;
				default: arrive_pct = 80;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7))
					: PRIO_W'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if (r < 5)
					burst = '0;
				else if (r < 85)
					burst = BURST_W'($urandom_range(1, 3));
				else if (r < 97)
					burst = BURST_W'($urandom_range(4, 40));
				else
					burst = BURST_W'($urandom_range(41, 255));
				if ($urandom_range(0, 99) < arrive_pct)
					offer(OP_ARRIVE, JOB_W'($urandom_range(0, 15)), prio, burst);
				else
					offer(OP_TICK, JOB_W'($urandom), PRIO_W'($urandom), BURST_W'($urandom));
				sent++;
			end
		end
		calm = 1'b0;

		// Let the queue empty, then run the longest bursts.
		for (int n = 0; n < DRAIN_TICKS; n++)
			offer(OP_TICK, JOB_W'($urandom), PRIO_W'($urandom), BURST_W'($urandom));
		offer(OP_ARRIVE, 4'hA, 8'h00, 16'hFFFF);
		offer(OP_ARRIVE, 4'h3, 8'hFF, 16'h8000);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		offer(OP_TICK, 4'h0, 8'h00, 16'h0000);
		@(negedge clk);
		in_valid <= 1'b0;

		// Wait for every owed record, then for work that gives no record.
		winding_down = 1'b1;
		while (records_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- nonpreemptive_priority_scheduler.f -----
rtl/core/nps_pkg.sv
rtl/core/nps_front.sv
rtl/core/nps_back.sv
rtl/core/nonpreemptive_priority_scheduler.sv
bench/nps_schedule_monitor.sv
bench/tb_nonpreemptive_priority_scheduler.sv
